[sv/polyline_path_length_defines.svh]
// ----------------------------------------------------------------------------
// Polyline path length assertion macros
// Concurrent check wrappers that drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_PATH_LENGTH_DEFINES_SVH
`define POLYLINE_PATH_LENGTH_DEFINES_SVH

`ifndef SYNTHESIS
// check that holds outside reset
`define PLPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that holds at every edge, reset included
`define PLPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLPL_ASSERT(lbl, prop, msg)
`define PLPL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/plpl_pkg.sv]
// ----------------------------------------------------------------------------
// Polyline path length package
// Shared widths, fixed-point constants and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package plpl_pkg;

  localparam int COORD_W         = 32;
  localparam int DIFF_W          = 32;              // |a - b| of two 32-bit values
  localparam int SQ_W            = 2 * DIFF_W;
  localparam int RAD_W           = SQ_W + 2;        // even width, holds the sum
  localparam int ROOT_W          = RAD_W / 2;
  localparam int REM_W           = ROOT_W + 3;
  localparam int TOTAL_W         = 64;
  localparam int COORD_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS   = 16;
  localparam int UP_SHIFT   = (COORD_FRAC_BITS < OUT_FRAC_BITS) ?
                              (OUT_FRAC_BITS - COORD_FRAC_BITS) : 0;
  localparam int DOWN_SHIFT = (COORD_FRAC_BITS > OUT_FRAC_BITS) ?
                              (COORD_FRAC_BITS - OUT_FRAC_BITS) : 0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_TOO_SHORT = 1'b1;

  typedef struct packed {
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    logic              has_seg;
    logic              last;
  } seg_t;

endpackage

`default_nettype wire

[sv/polyline_path_length.sv]
// A closing point beat passes the queue, square, sum, 33 root steps and
// accumulate; a single-point path goes from the queue straight to accumulate.
// The engine takes a segment only when idle, after its one-digit-per-cycle
// square root loop; a first point queues work only if it closes its path.
// Reset: synchronous rst clears the previous point, total, overflow flag,
// queue and result register.
// ----------------------------------------------------------------------------
// Polyline path length
// Sums Euclidean segment lengths of a point stream, emitting Q48.16 totals.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_path_length (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [plpl_pkg::COORD_W-1:0] x_coord,
  input  wire logic [plpl_pkg::COORD_W-1:0] y_coord,
  input  wire logic                         last_point,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [plpl_pkg::TOTAL_W-1:0]      path_length,
  output logic                              status,
  output logic                              saturated
);

  logic           push_valid;
  logic           push_ready;
  plpl_pkg::seg_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  plpl_pkg::seg_t pop_data;

  plpl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .last_point (last_point),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  plpl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  plpl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .path_length (path_length),
    .status      (status),
    .saturated   (saturated)
  );

endmodule

`default_nettype wire

[sv/plpl_queue.sv]
// ----------------------------------------------------------------------------
// Segment queue
// Short FIFO between the point front end and the length engine.
// ----------------------------------------------------------------------------
`default_nettype none

module plpl_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire plpl_pkg::seg_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output plpl_pkg::seg_t     pop_data
);

  plpl_pkg::seg_t                     mem [plpl_pkg::QUEUE_DEPTH];
  logic [plpl_pkg::QUEUE_AW-1:0]      wr_ptr;
  logic [plpl_pkg::QUEUE_AW-1:0]      rd_ptr;
  logic [plpl_pkg::QUEUE_CW-1:0]      count;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready = (count != plpl_pkg::QUEUE_CW'(plpl_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/plpl_front.sv]
// ----------------------------------------------------------------------------
// Point front end
// Holds the previous point, forms |dx| and |dy| and queues segment work.
// ----------------------------------------------------------------------------
`default_nettype none

module plpl_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [plpl_pkg::COORD_W-1:0] x_coord,
  input  wire logic [plpl_pkg::COORD_W-1:0] y_coord,
  input  wire logic                         last_point,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output plpl_pkg::seg_t                    push_data
);

  logic [plpl_pkg::COORD_W-1:0] prev_x;
  logic [plpl_pkg::COORD_W-1:0] prev_y;
  logic                         have_prev;
  logic [plpl_pkg::COORD_W:0]   diff_x;
  logic [plpl_pkg::COORD_W:0]   diff_y;
  logic [plpl_pkg::COORD_W:0]   abs_x;
  logic [plpl_pkg::COORD_W:0]   abs_y;

  // sign-extend both operands so the difference cannot wrap
  assign diff_x = {x_coord[plpl_pkg::COORD_W-1], x_coord} - {prev_x[plpl_pkg::COORD_W-1], prev_x};
  assign diff_y = {y_coord[plpl_pkg::COORD_W-1], y_coord} - {prev_y[plpl_pkg::COORD_W-1], prev_y};
  assign abs_x  = diff_x[plpl_pkg::COORD_W] ? (~diff_x + 1'b1) : diff_x;
  assign abs_y  = diff_y[plpl_pkg::COORD_W] ? (~diff_y + 1'b1) : diff_y;

  // a first point that does not close the path leaves no work behind
  assign in_ready           = push_ready;
  assign push_valid         = in_valid && (have_prev || last_point);
  assign push_data.dx       = abs_x[plpl_pkg::DIFF_W-1:0];
  assign push_data.dy       = abs_y[plpl_pkg::DIFF_W-1:0];
  assign push_data.has_seg  = have_prev;
  assign push_data.last     = last_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
    end else if (in_valid && in_ready) begin
      prev_x    <= x_coord;
      prev_y    <= y_coord;
      have_prev <= !last_point;
    end
  end

endmodule

`default_nettype wire

[sv/plpl_back.sv]
// ----------------------------------------------------------------------------
// Length engine
// Squares, takes a bit-serial integer square root and accumulates the total.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polyline_path_length_defines.svh"

module plpl_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pop_valid,
  output logic                              pop_ready,
  input  wire plpl_pkg::seg_t               pop_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [plpl_pkg::TOTAL_W-1:0]      path_length,
  output logic                              status,
  output logic                              saturated
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_ACC
  } state_t;

  state_t                          state;
  logic [plpl_pkg::DIFF_W-1:0]     dx;
  logic [plpl_pkg::DIFF_W-1:0]     dy;
  logic                            has_seg;
  logic                            last;
  logic [plpl_pkg::SQ_W-1:0]       sq_x;
  logic [plpl_pkg::SQ_W-1:0]       sq_y;
  logic [plpl_pkg::RAD_W-1:0]      rad;
  logic [plpl_pkg::REM_W-1:0]      rem;
  logic [plpl_pkg::ROOT_W-1:0]     root;
  logic [plpl_pkg::STEP_W-1:0]     step;
  logic [plpl_pkg::TOTAL_W-1:0]    total;
  logic                            ovf_seen;

  logic [plpl_pkg::REM_W-1:0]      rem_sh;
  logic [plpl_pkg::REM_W-1:0]      trial;
  logic                            take;
  logic [plpl_pkg::TOTAL_W-1:0]    seg_len;
  logic [plpl_pkg::TOTAL_W:0]      sum;
  logic [plpl_pkg::TOTAL_W-1:0]    total_next;
  logic                            ovf_next;
  logic                            stall;

  assign pop_ready = (state == ST_IDLE);

  // one root digit per cycle: bring down two radicand bits, try 4r+1
  assign rem_sh = {rem[plpl_pkg::REM_W-3:0], rad[plpl_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign take   = (rem_sh >= trial);

  assign seg_len = has_seg ?
      ((plpl_pkg::TOTAL_W'(root) << plpl_pkg::UP_SHIFT) >> plpl_pkg::DOWN_SHIFT) : '0;
  assign sum        = {1'b0, total} + {1'b0, seg_len};
  assign total_next = sum[plpl_pkg::TOTAL_W] ? '1 : sum[plpl_pkg::TOTAL_W-1:0];
  assign ovf_next   = ovf_seen || sum[plpl_pkg::TOTAL_W];

  // hold the closing beat while the previous result is still unclaimed
  assign stall = last && out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      total       <= '0;
      ovf_seen    <= 1'b0;
      out_valid   <= 1'b0;
      path_length <= '0;
      status      <= plpl_pkg::STATUS_OK;
      saturated   <= 1'b0;
    end else begin
      if (state == ST_ACC && last && !stall) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            dx      <= pop_data.dx;
            dy      <= pop_data.dy;
            has_seg <= pop_data.has_seg;
            last    <= pop_data.last;
            root    <= '0;
            state   <= pop_data.has_seg ? ST_SQUARE : ST_ACC;
          end
        end
        ST_SQUARE: begin
          sq_x  <= dx * dx;
          sq_y  <= dy * dy;
          state <= ST_SUM;
        end
        ST_SUM: begin
          rad   <= plpl_pkg::RAD_W'(sq_x) + plpl_pkg::RAD_W'(sq_y);
          rem   <= '0;
          root  <= '0;
          step  <= plpl_pkg::STEP_W'(plpl_pkg::ROOT_STEPS - 1);
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          rad  <= rad << 2;
          rem  <= take ? (rem_sh - trial) : rem_sh;
          root <= {root[plpl_pkg::ROOT_W-2:0], take};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (!stall) begin
            state <= ST_IDLE;
            if (last) begin
              path_length <= has_seg ? total_next : '0;
              status      <= has_seg ? plpl_pkg::STATUS_OK : plpl_pkg::STATUS_TOO_SHORT;
              saturated   <= has_seg && ovf_next;
              total       <= '0;
              ovf_seen    <= 1'b0;
            end else begin
              total    <= total_next;
              ovf_seen <= ovf_next;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PLPL_ASSERT(a_short_path_clean,
    out_valid && status == plpl_pkg::STATUS_TOO_SHORT |-> path_length == '0 && !saturated,
    "short path result carries length or saturation")
  `PLPL_ASSERT(a_ovf_pins_total, ovf_seen |-> total == '1,
    "overflow seen but total not pinned at maximum")
  `PLPL_ASSERT(a_clear_after_close, state == ST_ACC && last && !stall |=> total == '0 && !ovf_seen,
    "path state not cleared after closing beat")
  `PLPL_ASSERT_ALWAYS(a_no_pop_while_busy, state != ST_IDLE |-> !pop_ready,
    "queue popped while engine busy")

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Polyline path length testbench
// Streams points through the block with random gaps and back-pressure and
// predicts every path total with an independent fixed-point model.
// Each emitted result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_POINTS = 1600;
  localparam int DRAIN_CYCLES  = 60;
  localparam int MAX_PRINTS    = 50;

  typedef logic [plpl_pkg::COORD_W-1:0] coord_t;

  // Predicts path totals from accepted points and holds the results to come.
  class path_scoreboard;
    typedef struct {
      logic [plpl_pkg::TOTAL_W-1:0] length;
      logic                         status;
      logic                         sat;
    } path_total_t;

    coord_t                       prev_x;
    coord_t                       prev_y;
    bit                           have_prev;
    logic [plpl_pkg::TOTAL_W-1:0] total;
    bit                           clipped;
    path_total_t                  totals_due[$];
    int                           errors;

    function new();
      clear_path();
      errors = 0;
    endfunction

    function void clear_path();
      prev_x    = '0;
      prev_y    = '0;
      have_prev = 0;
      total     = '0;
      clipped   = 0;
    endfunction

    function int pending();
      return totals_due.size();
    endfunction

    // Floor square root of a 66-bit radicand, one bit per pass.
    function logic [plpl_pkg::ROOT_W-1:0] floor_root(logic [plpl_pkg::RAD_W-1:0] rad);
      logic [plpl_pkg::ROOT_W-1:0] r;
      logic [plpl_pkg::ROOT_W-1:0] c;
      logic [plpl_pkg::RAD_W-1:0]  sq;
      r = '0;
      for (int b = plpl_pkg::ROOT_W - 1; b >= 0; b--) begin
        c  = r | (plpl_pkg::ROOT_W'(1) << b);
        sq = plpl_pkg::RAD_W'(c) * plpl_pkg::RAD_W'(c);
        if (sq <= rad) r = c;
      end
      return r;
    endfunction

    function logic [plpl_pkg::RAD_W-1:0] segment(coord_t x, coord_t y);
      logic signed [plpl_pkg::COORD_W:0] dx;
      logic signed [plpl_pkg::COORD_W:0] dy;
      logic [plpl_pkg::RAD_W-1:0]        rad;
      logic [plpl_pkg::RAD_W-1:0]        len;
      dx  = $signed({x[plpl_pkg::COORD_W-1], x})
          - $signed({prev_x[plpl_pkg::COORD_W-1], prev_x});
      dy  = $signed({y[plpl_pkg::COORD_W-1], y})
          - $signed({prev_y[plpl_pkg::COORD_W-1], prev_y});
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      rad = plpl_pkg::RAD_W'($unsigned(dx)) * plpl_pkg::RAD_W'($unsigned(dx))
          + plpl_pkg::RAD_W'($unsigned(dy)) * plpl_pkg::RAD_W'($unsigned(dy));
      len = plpl_pkg::RAD_W'(floor_root(rad));
      return (len << plpl_pkg::UP_SHIFT) >> plpl_pkg::DOWN_SHIFT;
    endfunction

    function void note_point(coord_t x, coord_t y, bit last);
      logic [plpl_pkg::RAD_W-1:0] sum;
      path_total_t                res;
      bit                         had;
      had = have_prev;
      if (had) begin
        sum = plpl_pkg::RAD_W'(total) + segment(x, y);
        if (sum[plpl_pkg::RAD_W-1:plpl_pkg::TOTAL_W] != '0) begin
          total   = '1;
          clipped = 1;
        end else begin
          total = sum[plpl_pkg::TOTAL_W-1:0];
        end
      end
      prev_x    = x;
      prev_y    = y;
      have_prev = 1;
      if (last) begin
        if (had) begin
          res.length = total;
          res.status = plpl_pkg::STATUS_OK;
          res.sat    = clipped;
        end else begin
          res.length = '0;
          res.status = plpl_pkg::STATUS_TOO_SHORT;
          res.sat    = 1'b0;
        end
        totals_due.push_back(res);
        clear_path();
      end
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [plpl_pkg::TOTAL_W-1:0] length, logic st, logic sat);
      path_total_t want;
      if (totals_due.size() == 0) begin
        report($sformatf("unexpected result length=%h status=%b", length, st));
        return;
      end
      want = totals_due.pop_front();
      if (length !== want.length)
        report($sformatf("path_length %h, want %h", length, want.length));
      if (st !== want.status)
        report($sformatf("status %b, want %b", st, want.status));
      if (sat !== want.sat)
        report($sformatf("saturated %b, want %b", sat, want.sat));
    endtask
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  coord_t                       x_coord;
  coord_t                       y_coord;
  logic                         last_point;
  logic                         out_valid;
  logic                         out_ready;
  logic [plpl_pkg::TOTAL_W-1:0] path_length;
  logic                         status;
  logic                         saturated;

  path_scoreboard sb = new();
  int             points_sent;
  bit             calm;

  polyline_path_length u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .last_point (last_point),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .path_length(path_length),
    .status     (status),
    .saturated  (saturated)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function bit idle_now();
    return !calm && ($urandom_range(0, 99) < 15);
  endfunction

  function coord_t extreme_coord();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Offer one point and hold it until the block takes the beat.
  task automatic send_point(coord_t x, coord_t y, bit last);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    x_coord    <= x;
    y_coord    <= y;
    last_point <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_point(x, y, last);
    points_sent++;
  endtask

  task automatic send_random_path();
    int     len;
    int     flavor;
    coord_t x;
    coord_t y;
    len    = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
    flavor = $urandom_range(0, 9);
    x      = $urandom;
    y      = $urandom;
    for (int k = 0; k < len; k++) begin
      if (flavor < 4) begin
        x = $urandom;
        y = $urandom;
      end else if (flavor < 8) begin
        // walk in small steps around the current point
        x = x + coord_t'($urandom_range(0, 1 << 18)) - coord_t'(1 << 17);
        y = y + coord_t'($urandom_range(0, 1 << 18)) - coord_t'(1 << 17);
      end else begin
        x = extreme_coord();
        y = extreme_coord();
      end
      send_point(x, y, k == len - 1);
    end
  endtask

  // Result side: random stalls plus one long hold-off that backs up the block.
  initial begin
    int cycles;
    out_ready <= 1'b0;
    cycles = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= 1500 && cycles < 2100)
        out_ready <= 1'b0;
      else
        out_ready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(path_length, status, saturated);
  end

  initial begin
    bit paused;
    rst         = 1'b1;
    in_valid   <= 1'b0;
    x_coord    <= '0;
    y_coord    <= '0;
    last_point <= 1'b0;
    calm        = 0;
    paused      = 0;
    points_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-point paths
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b1);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
    // longest possible segments, sum of squares above 64 bits
    send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    // repeated points add nothing
    send_point(32'h0005_0000, 32'h0007_0000, 1'b0);
    send_point(32'h0005_0000, 32'h0007_0000, 1'b0);
    send_point(32'h0005_0000, 32'h0007_0000, 1'b1);
    // 3-4-5 triangle, then back across zero
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0003_0000, 32'h0004_0000, 1'b0);
    send_point(32'hfffd_0000, 32'hfffc_0000, 1'b1);
    // smallest nonzero steps
    send_point(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0000_0001, 32'h0000_0000, 1'b1);
    // zig-zag between the corners
    send_point(32'h8000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h7fff_ffff, 32'hffff_ffff, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b1);

    while (points_sent < RANDOM_POINTS) begin
      calm = (points_sent >= 1000 && points_sent < 1250);
      send_random_path();
      if (!paused && points_sent >= 700) begin
        // let the block drain completely before going on
        paused = 1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
    end
    calm = 0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[polyline_path_length] OK");
    else
      $display("[polyline_path_length] ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[polyline_path_length] ERROR");
    $finish;
  end

endmodule
